// ===== sv/vcpr_pkg.sv =====
`timescale 1ns / 1ps

package vcpr_pkg;

    localparam int PAL_WORDS = 512;

    localparam logic [11:0] AREA_PAL = 12'h400;
    localparam logic [11:0] AREA_R0  = 12'h500;
    localparam logic [11:0] AREA_R1  = 12'h600;
    localparam logic [11:0] AREA_R2  = 12'h700;

    localparam logic [7:0] PRIO_HIGH_MASK = 8'h3f;
    localparam logic [7:0] SHADOW_RESET   = 8'hff;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

// ===== sv/vcpr_ram.sv =====
`timescale 1ns / 1ps

module vcpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/video_ctrl_palette_regs_unit.sv =====
`timescale 1ns / 1ps

// Output: the result of an item is registered as it leaves ST_EXEC; a stalled
// output holds the item there. No new item is accepted until then. The palette
// word is read when the item is accepted, before its compare and write-back.
// Reset: a clearing pass writes zero to all PALETTE_WORDS palette entries,
// during which no item is accepted; mode registers clear and shadows load 0xff.
module video_ctrl_palette_regs_unit
    import vcpr_pkg::*;
#(
    parameter int PALETTE_WORDS = PAL_WORDS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic        size,
    input  logic [12:0] offset,
    input  logic [15:0] wdata,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] rdata,
    output logic        palette_wait,
    output logic        palette_changed,
    output logic [8:0]  palette_index,
    output logic        mode_changed,
    output logic [2:0]  mode_reg0,
    output logic [13:0] priority_word,
    output logic [15:0] enable_word
);

    localparam int IDX_W = $clog2(PALETTE_WORDS);

    state_t state_reg, state_next;

    logic [IDX_W-1:0] clr_cnt_reg;
    logic             clr_last;

    // Item held while its palette word is being read.
    logic        func_reg;
    logic        size_reg;
    logic [11:0] off_reg;
    logic [15:0] wdata_reg;

    logic        size_bit_reg, size_bit_next;
    logic [1:0]  color_mode_reg, color_mode_next;
    logic [13:0] prio_reg, prio_next;
    logic [15:0] enable_reg, enable_next;
    logic [7:0]  sh_prio_hi_reg, sh_prio_hi_next;
    logic [7:0]  sh_prio_lo_reg, sh_prio_lo_next;
    logic [7:0]  sh_en_hi_reg, sh_en_hi_next;
    logic [7:0]  sh_en_lo_reg, sh_en_lo_next;

    logic        out_valid_reg;
    logic [15:0] rdata_reg;
    logic        pwait_reg;
    logic        pchg_reg;
    logic [8:0]  pidx_reg;
    logic        mchg_reg;

    logic             accept;
    logic             fire;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [15:0]      ram_wdata;
    logic [15:0]      ram_rdata;
    logic [11:0]      in_off;

    logic [11:0]      off_eff;
    logic             high_byte;
    logic             pal_hit;
    logic [IDX_W-1:0] idx;
    logic [15:0]      pal_new;
    logic [15:0]      full;
    logic [15:0]      rd_val;
    logic             pchg;
    logic             mchg;
    logic [7:0]       hi_val;

    assign in_off   = offset[11:0];
    assign clr_last = (clr_cnt_reg == IDX_W'(PALETTE_WORDS - 1));
    assign accept   = in_valid && !in_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_stall  = 1'b1;
        fire      = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = idx;
        ram_wdata = pal_new;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_EXEC:
            begin
                fire   = !out_valid_reg || !out_stall;
                ram_we = fire && pal_hit && (func_reg == FUNC_WRITE);
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    vcpr_ram #(
        .WIDTH (16),
        .DEPTH (PALETTE_WORDS)
    ) u_pal_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_off[IDX_W:1]),
        .rdata (ram_rdata)
    );

    // Decode and read-modify-write of the held item.
    always_comb
    begin
        off_eff   = {off_reg[11:1], off_reg[0] & !size_reg};
        high_byte = !off_eff[0];
        pal_hit   = (off_eff < AREA_PAL);
        idx       = off_eff[IDX_W:1];

        size_bit_next   = size_bit_reg;
        color_mode_next = color_mode_reg;
        prio_next       = prio_reg;
        enable_next     = enable_reg;
        sh_prio_hi_next = sh_prio_hi_reg;
        sh_prio_lo_next = sh_prio_lo_reg;
        sh_en_hi_next   = sh_en_hi_reg;
        sh_en_lo_next   = sh_en_lo_reg;
        mchg            = 1'b0;
        full            = '0;
        hi_val          = size_reg ? wdata_reg[15:8] : wdata_reg[7:0];

        if (size_reg)
        begin
            pal_new = wdata_reg;
        end
        else if (high_byte)
        begin
            pal_new = {wdata_reg[7:0], ram_rdata[7:0]};
        end
        else
        begin
            pal_new = {ram_rdata[15:8], wdata_reg[7:0]};
        end
        pchg = pal_hit && (func_reg == FUNC_WRITE) && (pal_new != ram_rdata);

        priority if (pal_hit)
        begin
            full = ram_rdata;
        end
        else if (off_eff < AREA_R0)
        begin
            full = {13'd0, size_bit_reg, color_mode_reg};
            if ((func_reg == FUNC_WRITE) && (size_reg || !high_byte))
            begin
                size_bit_next   = wdata_reg[2];
                color_mode_next = wdata_reg[1:0];
                mchg = (wdata_reg[2] != size_bit_reg) || (wdata_reg[1:0] != color_mode_reg);
            end
        end
        else if (off_eff < AREA_R1)
        begin
            full = {2'd0, prio_reg};
            if (func_reg == FUNC_WRITE)
            begin
                if (size_reg || high_byte)
                begin
                    mchg            = mchg || (sh_prio_hi_reg != (hi_val & PRIO_HIGH_MASK));
                    sh_prio_hi_next = hi_val & PRIO_HIGH_MASK;
                    prio_next[13:8] = hi_val[5:0];
                end
                if (size_reg || !high_byte)
                begin
                    mchg            = mchg || (sh_prio_lo_reg != wdata_reg[7:0]);
                    sh_prio_lo_next = wdata_reg[7:0];
                    prio_next[7:0]  = wdata_reg[7:0];
                end
            end
        end
        else if (off_eff < AREA_R2)
        begin
            full = enable_reg;
            if (func_reg == FUNC_WRITE)
            begin
                if (size_reg || high_byte)
                begin
                    mchg              = mchg || (sh_en_hi_reg != hi_val);
                    sh_en_hi_next     = hi_val;
                    enable_next[15:8] = hi_val;
                end
                if (size_reg || !high_byte)
                begin
                    mchg             = mchg || (sh_en_lo_reg != wdata_reg[7:0]);
                    sh_en_lo_next    = wdata_reg[7:0];
                    enable_next[7:0] = wdata_reg[7:0];
                end
            end
        end
        else
        begin
            // Unmapped space reads as zero and ignores writes.
            full = '0;
        end

        if (func_reg == FUNC_WRITE)
        begin
            rd_val = '0;
        end
        else if (size_reg)
        begin
            rd_val = full;
        end
        else if (high_byte)
        begin
            rd_val = {8'd0, full[15:8]};
        end
        else
        begin
            rd_val = {8'd0, full[7:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            size_bit_reg   <= 1'b0;
            color_mode_reg <= '0;
            prio_reg       <= '0;
            enable_reg     <= '0;
            sh_prio_hi_reg <= SHADOW_RESET;
            sh_prio_lo_reg <= SHADOW_RESET;
            sh_en_hi_reg   <= SHADOW_RESET;
            sh_en_lo_reg   <= SHADOW_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (fire)
            begin
                out_valid_reg  <= 1'b1;
                size_bit_reg   <= size_bit_next;
                color_mode_reg <= color_mode_next;
                prio_reg       <= prio_next;
                enable_reg     <= enable_next;
                sh_prio_hi_reg <= sh_prio_hi_next;
                sh_prio_lo_reg <= sh_prio_lo_next;
                sh_en_hi_reg   <= sh_en_hi_next;
                sh_en_lo_reg   <= sh_en_lo_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            size_reg  <= size;
            off_reg   <= in_off;
            wdata_reg <= wdata;
        end
        if (fire)
        begin
            rdata_reg <= rd_val;
            pwait_reg <= pal_hit;
            pchg_reg  <= pchg;
            pidx_reg  <= pal_hit ? 9'(idx) : 9'd0;
            mchg_reg  <= mchg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign rdata           = rdata_reg;
    assign palette_wait    = pwait_reg;
    assign palette_changed = pchg_reg;
    assign palette_index   = pidx_reg;
    assign mode_changed    = mchg_reg;
    assign mode_reg0       = {size_bit_reg, color_mode_reg};
    assign priority_word   = prio_reg;
    assign enable_word     = enable_reg;

endmodule

// ===== tb/tb_video_ctrl_palette_regs_unit.sv =====
`timescale 1ns / 1ps

module tb_video_ctrl_palette_regs_unit;
    import vcpr_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 6;

    typedef struct {
        logic [15:0] rdata;
        logic        pal_wait;
        logic        pal_changed;
        logic [8:0]  pal_index;
        logic        mode_changed;
        logic [2:0]  mode_reg0;
        logic [13:0] prio_word;
        logic [15:0] enab_word;
    } bus_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic        size;
    logic [12:0] offset;
    logic [15:0] wdata;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] rdata;
    logic        palette_wait;
    logic        palette_changed;
    logic [8:0]  palette_index;
    logic        mode_changed;
    logic [2:0]  mode_reg0;
    logic [13:0] priority_word;
    logic [15:0] enable_word;

    // Predicted contents of the palette and the mode registers.
    logic [15:0] pal_mem [PAL_WORDS];
    logic        size_bit;
    logic [1:0]  color_mode;
    logic [13:0] prio_bits;
    logic [15:0] enable_bits;
    logic [7:0]  shadow_prio_hi;
    logic [7:0]  shadow_prio_lo;
    logic [7:0]  shadow_enab_hi;
    logic [7:0]  shadow_enab_lo;

    bus_result_t pending_bus_results [$];
    bus_result_t want_res;

    int error_count;
    int results_checked;
    int reads_sent;
    int writes_sent;
    int pal_changes_seen;
    int mode_changes_seen;
    int cycle_count = 0;
    int gap_pct;
    int stall_pct;
    int hold_cycles;

    video_ctrl_palette_regs_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .size            (size),
        .offset          (offset),
        .wdata           (wdata),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .rdata           (rdata),
        .palette_wait    (palette_wait),
        .palette_changed (palette_changed),
        .palette_index   (palette_index),
        .mode_changed    (mode_changed),
        .mode_reg0       (mode_reg0),
        .priority_word   (priority_word),
        .enable_word     (enable_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Applies one bus access to the predicted state and returns what the block should report.
    function automatic bus_result_t model_bus_access(input logic f, input logic s,
                                                     input logic [12:0] o, input logic [15:0] w);
        logic [11:0] addr;
        logic        high_half;
        logic [8:0]  idx;
        logic [15:0] old_word;
        logic [15:0] new_word;
        logic [15:0] full;
        logic [7:0]  half;
        bus_result_t r;

        addr = o[11:0];
        if (s)
            addr[0] = 1'b0;
        high_half = ~addr[0];
        full = '0;
        r.rdata = '0;
        r.pal_wait = 1'b0;
        r.pal_changed = 1'b0;
        r.pal_index = '0;
        r.mode_changed = 1'b0;

        if (addr < AREA_PAL)
        begin
            r.pal_wait = 1'b1;
            idx = addr[9:1];
            r.pal_index = idx;
            old_word = pal_mem[idx];
            if (f == FUNC_WRITE)
            begin
                if (s)
                    new_word = w;
                else if (high_half)
                    new_word = {w[7:0], old_word[7:0]};
                else
                    new_word = {old_word[15:8], w[7:0]};
                r.pal_changed = (new_word != old_word);
                pal_mem[idx] = new_word;
            end
            else
                full = old_word;
        end
        else if (addr < AREA_R0)
        begin
            // The high byte of the first mode register holds nothing.
            if (f == FUNC_WRITE)
            begin
                if (s || !high_half)
                begin
                    r.mode_changed = ({w[2], w[1:0]} != {size_bit, color_mode});
                    size_bit = w[2];
                    color_mode = w[1:0];
                end
            end
            else
                full = {13'b0, size_bit, color_mode};
        end
        else if (addr < AREA_R1)
        begin
            if (f == FUNC_WRITE)
            begin
                if (s || high_half)
                begin
                    half = (s ? w[15:8] : w[7:0]) & PRIO_HIGH_MASK;
                    if (half != shadow_prio_hi)
                        r.mode_changed = 1'b1;
                    shadow_prio_hi = half;
                    prio_bits[13:8] = half[5:0];
                end
                if (s || !high_half)
                begin
                    if (w[7:0] != shadow_prio_lo)
                        r.mode_changed = 1'b1;
                    shadow_prio_lo = w[7:0];
                    prio_bits[7:0] = w[7:0];
                end
            end
            else
                full = {2'b0, prio_bits};
        end
        else if (addr < AREA_R2)
        begin
            if (f == FUNC_WRITE)
            begin
                if (s || high_half)
                begin
                    half = s ? w[15:8] : w[7:0];
                    if (half != shadow_enab_hi)
                        r.mode_changed = 1'b1;
                    shadow_enab_hi = half;
                    enable_bits[15:8] = half;
                end
                if (s || !high_half)
                begin
                    if (w[7:0] != shadow_enab_lo)
                        r.mode_changed = 1'b1;
                    shadow_enab_lo = w[7:0];
                    enable_bits[7:0] = w[7:0];
                end
            end
            else
                full = enable_bits;
        end

        if (f == FUNC_READ)
        begin
            if (s)
                r.rdata = full;
            else if (high_half)
                r.rdata = {8'h00, full[15:8]};
            else
                r.rdata = {8'h00, full[7:0]};
        end
        r.mode_reg0 = {size_bit, color_mode};
        r.prio_word = prio_bits;
        r.enab_word = enable_bits;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH %s: got %h, expected %h (result %0d)", what, got, want,
                 results_checked);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bus_results.size() == 0)
                report_mismatch("unexpected result, rdata", rdata, 16'h0000);
            else
            begin
                want_res = pending_bus_results.pop_front();
                if (rdata !== want_res.rdata)
                    report_mismatch("rdata", rdata, want_res.rdata);
                if (palette_wait !== want_res.pal_wait)
                    report_mismatch("palette_wait", 16'(palette_wait),
                                    16'(want_res.pal_wait));
                if (palette_changed !== want_res.pal_changed)
                    report_mismatch("palette_changed", 16'(palette_changed),
                                    16'(want_res.pal_changed));
                if (palette_index !== want_res.pal_index)
                    report_mismatch("palette_index", 16'(palette_index),
                                    16'(want_res.pal_index));
                if (mode_changed !== want_res.mode_changed)
                    report_mismatch("mode_changed", 16'(mode_changed),
                                    16'(want_res.mode_changed));
                if (mode_reg0 !== want_res.mode_reg0)
                    report_mismatch("mode_reg0", 16'(mode_reg0), 16'(want_res.mode_reg0));
                if (priority_word !== want_res.prio_word)
                    report_mismatch("priority_word", 16'(priority_word),
                                    16'(want_res.prio_word));
                if (enable_word !== want_res.enab_word)
                    report_mismatch("enable_word", enable_word, want_res.enab_word);
                if (want_res.pal_changed)
                    pal_changes_seen++;
                if (want_res.mode_changed)
                    mode_changes_seen++;
            end
            results_checked++;
        end
    end

    // The result side stalls in random bursts, or holds off for a long stretch on request.
    initial
    begin : result_stall_driver
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Called at a rising edge; returns at the edge where the item was taken, or after a random gap that follows it.
    task automatic send_item(input logic f, input logic s, input logic [12:0] o,
                             input logic [15:0] w);
        bus_result_t res;
        in_valid <= 1'b1;
        func <= f;
        size <= s;
        offset <= o;
        wdata <= w;
        do
            @(posedge clk);
        while (in_stall);
        res = model_bus_access(f, s, o, w);
        pending_bus_results.push_back(res);
        if (f == FUNC_WRITE)
            writes_sent++;
        else
            reads_sent++;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_bus_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic pick_random_access(output logic f, output logic s, output logic [12:0] o,
                                      output logic [15:0] w);
        int sel;
        logic [15:0] cur;
        sel = $urandom_range(0, 99);
        f = 1'($urandom_range(0, 1));
        s = 1'($urandom_range(0, 1));
        if (sel < 45)
            o = 13'($urandom_range(0, 12'h3ff));
        else if (sel < 82)
            o = 13'($urandom_range(12'h400, 12'h6ff));
        else
            o = 13'($urandom_range(12'h700, 12'hfff));
        o[12] = 1'($urandom_range(0, 1));
        w = 16'($urandom_range(0, 16'hffff));
        // Now and then rewrite what is already stored, so that the change flags stay low.
        if (f == FUNC_WRITE && $urandom_range(0, 4) == 0)
        begin
            if (o[11:0] < AREA_PAL)
                cur = pal_mem[o[9:1]];
            else if (o[11:0] < AREA_R0)
                cur = {13'b0, size_bit, color_mode};
            else if (o[11:0] < AREA_R1)
                cur = {2'b0, prio_bits};
            else
                cur = enable_bits;
            w = (s || o[0]) ? cur : {cur[7:0], cur[15:8]};
        end
    endtask

    task automatic send_random_items(input int count);
        logic        f;
        logic        s;
        logic [12:0] o;
        logic [15:0] w;
        repeat (count)
        begin
            pick_random_access(f, s, o, w);
            send_item(f, s, o, w);
        end
    endtask

    task automatic test_reset_values();
        gap_pct = 20;
        stall_pct = 10;
        send_item(FUNC_READ, 1'b1, 13'h0000, 16'hffff);
        send_item(FUNC_READ, 1'b1, 13'h03fe, 16'h0000);
        send_item(FUNC_READ, 1'b0, 13'h0401, 16'h0000);
        send_item(FUNC_READ, 1'b1, 13'h0600, 16'h0000);
        send_item(FUNC_READ, 1'b1, 13'h0abc, 16'h0000);
        wait_drained();
    endtask

    task automatic test_palette_access();
        send_item(FUNC_WRITE, 1'b1, 13'h0002, 16'hffff);
        // Word access at an odd offset lands on the same word.
        send_item(FUNC_WRITE, 1'b1, 13'h0003, 16'hffff);
        send_item(FUNC_WRITE, 1'b0, 13'h0002, 16'hab12);
        // Offset bit 12 is a mirror.
        send_item(FUNC_WRITE, 1'b0, 13'h1003, 16'h5534);
        send_item(FUNC_READ,  1'b0, 13'h0002, 16'h0000);
        send_item(FUNC_READ,  1'b0, 13'h1003, 16'h0000);
        send_item(FUNC_WRITE, 1'b1, 13'h13ff, 16'h8001);
        send_item(FUNC_READ,  1'b1, 13'h03fe, 16'h0000);
        wait_drained();
    endtask

    task automatic test_mode_registers();
        send_item(FUNC_WRITE, 1'b1, 13'h0400, 16'hffff);
        // The high byte of the first register ignores writes.
        send_item(FUNC_WRITE, 1'b0, 13'h0400, 16'h0000);
        send_item(FUNC_WRITE, 1'b0, 13'h04ff, 16'h0007);
        send_item(FUNC_READ,  1'b0, 13'h0400, 16'h0000);
        // The enable shadow starts at all ones, so this write changes the field silently.
        send_item(FUNC_WRITE, 1'b0, 13'h0601, 16'h00ff);
        send_item(FUNC_WRITE, 1'b0, 13'h0600, 16'hff00);
        send_item(FUNC_WRITE, 1'b1, 13'h0500, 16'hffff);
        // Only six bits of the priority high byte are stored and compared.
        send_item(FUNC_WRITE, 1'b0, 13'h0500, 16'h00ff);
        send_item(FUNC_WRITE, 1'b0, 13'h05fe, 16'h00c0);
        send_item(FUNC_READ,  1'b1, 13'h15fe, 16'h0000);
        send_item(FUNC_READ,  1'b0, 13'h06ff, 16'h0000);
        send_item(FUNC_WRITE, 1'b1, 13'h0700, 16'hffff);
        send_item(FUNC_READ,  1'b1, 13'h1fff, 16'h0000);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int chunk;
        for (chunk = 0; chunk < 5; chunk++)
        begin
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 10;
                default: gap_pct = 35;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 10;
                default: stall_pct = 30;
            endcase
            send_random_items(50);
        end
        wait_drained();
    endtask

    // The result side holds off while items keep coming, so the block must stall its input.
    task automatic test_backpressure();
        gap_pct = 0;
        stall_pct = 0;
        hold_cycles = 120;
        send_random_items(40);
        wait_drained();
    endtask

    task automatic test_steady_stream();
        gap_pct = 0;
        stall_pct = 0;
        send_random_items(300);
        wait_drained();
    endtask

    initial
    begin
        int i;
        error_count = 0;
        results_checked = 0;
        reads_sent = 0;
        writes_sent = 0;
        pal_changes_seen = 0;
        mode_changes_seen = 0;
        gap_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        for (i = 0; i < PAL_WORDS; i++)
            pal_mem[i] = 16'h0000;
        size_bit = 1'b0;
        color_mode = 2'b00;
        prio_bits = '0;
        enable_bits = '0;
        shadow_prio_hi = SHADOW_RESET;
        shadow_prio_lo = SHADOW_RESET;
        shadow_enab_hi = SHADOW_RESET;
        shadow_enab_lo = SHADOW_RESET;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        func <= FUNC_READ;
        size <= 1'b0;
        offset <= '0;
        wdata <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_palette_access();
        test_mode_registers();
        test_random_traffic();
        test_backpressure();
        test_steady_stream();

        $display("Checked %0d results from %0d reads and %0d writes.", results_checked,
                 reads_sent, writes_sent);
        $display("Palette changes: %0d, mode register changes: %0d, long hold-off included.",
                 pal_changes_seen, mode_changes_seen);
        if (error_count == 0 && pending_bus_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
